// File: rtl/core/twwc_pkg.sv
// Shared types and constants for the text window write capture block.
// Used by twwc_ctrl, twwc_dp and text_window_write_capture; depends on nothing.

package twwc_pkg;

    // Default size of one shadow slot in bytes
    localparam int DEF_SLOT_BYTES = 8192;

    // Byte counts and window ends: 2*255*255 plus a 16-bit base fits in 18 bits
    localparam int CNT_W = 18;

    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OFFSET_W   = 13;

    localparam logic [7:0] RECORD_SHOW = 8'h02;

    typedef enum logic [1:0] {
        CMD_POLL   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_GAP    = 2'd2,
        CMD_RECORD = 2'd3
    } t_cmd_code;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_BASE = 3'd0,
        REG_AUX_BANK    = 3'd1,
        REG_COLUMNS     = 3'd2,
        REG_ROWS        = 3'd3,
        REG_FILL_GLYPH  = 3'd4,
        REG_FILL_ATTR   = 3'd5
    } t_reg_idx;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic arm_start;
        logic fill_step;
        logic commit;
        logic ack_commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_arm;
        logic fill_done;
        logic out_free;
    } t_dp_sts;

endpackage

// File: rtl/core/text_window_write_capture.sv
// Text window write capture: top level joining the controller and datapath.
// Depends on twwc_pkg, twwc_ctrl and twwc_dp.
//
// Usage:
//   Items enter on the s_axis channel: tuser carries the command (poll, bus
//   write, frame gap, command record), tdata the poll flags, bus write address
//   and data, and record code. Each item yields exactly one result on m_axis.
//   Settings are written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata while
//   the block is idle; indexes 0..5 are window base, aux bank select, columns,
//   rows, fill glyph and fill attribute.
//   A poll, write, gap or record is first registered, then decoded against the
//   latched window and loaded into the result register when it is free.
//   A poll with an arm request fills min(2*cols*rows, SLOT_BYTES) bytes:
//   the fill walks the chosen slot one byte per cycle through the single
//   write port of the shadow store.
//   The result register decouples the sides: a stalled receiver holds the
//   result on m_axis while the next item is taken and worked on; that item
//   then waits until the held result is taken.
//   Reset clears the capture valid flag, slot choice and settings; the shadow
//   store content stays undefined until filled or written.

module text_window_write_capture #(
    parameter int SLOT_BYTES = twwc_pkg::DEF_SLOT_BYTES
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [twwc_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [twwc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // arm_request, active_slot, armed_flag, busy_flag, write_address[23:0],
    // write_data[7:0], record_code[7:0], zero pad
    input  logic [twwc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // command[1:0]
    input  logic [twwc_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // ack_arm, armed_slot, mark_stale, show_drained, capture_valid,
    // write_stored, store_offset[12:0], window_clipped, zero pad
    output logic [twwc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import twwc_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    twwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    twwc_dp #(
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_tuser  (s_axis_tuser),
        .i_in_tdata  (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_tdata (m_axis_tdata)
    );

endmodule

// File: rtl/core/twwc_ctrl.sv
// Sequencing controller for the text window write capture block.
// Depends on twwc_pkg; drives twwc_dp through t_dp_cmd and reads t_dp_sts.

module twwc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  twwc_pkg::t_dp_sts  i_sts,
    output twwc_pkg::t_dp_cmd  o_cmd
);
    import twwc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_FILL = 4'b0100,
        S_ACK  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.is_arm) begin
                    o_cmd.arm_start = 1'b1;
                    n_state         = S_FILL;
                end else if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_FILL: begin
                if (i_sts.fill_done) begin
                    n_state = S_ACK;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            S_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.ack_commit = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: rtl/core/twwc_dp.sv
// Datapath for the text window write capture block: settings, item and result
// registers, window decode, fill counter and the two-slot shadow store.
// Depends on twwc_pkg; commanded by twwc_ctrl.

module twwc_dp #(
    parameter int SLOT_BYTES = twwc_pkg::DEF_SLOT_BYTES
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [twwc_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [twwc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [twwc_pkg::IN_USER_W-1:0]      i_in_tuser,
    input  logic [twwc_pkg::IN_DATA_W-1:0]      i_in_tdata,
    input  twwc_pkg::t_dp_cmd                   i_cmd,
    output twwc_pkg::t_dp_sts                   o_sts,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [twwc_pkg::OUT_DATA_W-1:0]     o_out_tdata
);
    import twwc_pkg::*;

    localparam int MEM_DEPTH = 2 * SLOT_BYTES;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [CNT_W-1:0] SLOT_LIMIT = CNT_W'(SLOT_BYTES);
    localparam logic [AW-1:0]    SLOT_BASE  = AW'(SLOT_BYTES);

    // Configuration registers
    logic [15:0] r_cfg_base;
    logic        r_cfg_aux;
    logic [7:0]  r_cfg_cols;
    logic [7:0]  r_cfg_rows;
    logic [7:0]  r_cfg_glyph;
    logic [7:0]  r_cfg_attr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_base  <= '0;
            r_cfg_aux   <= 1'b0;
            r_cfg_cols  <= '0;
            r_cfg_rows  <= '0;
            r_cfg_glyph <= '0;
            r_cfg_attr  <= '0;
        end else if (i_cfg_wr_en) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_WINDOW_BASE: r_cfg_base  <= i_cfg_wdata;
                REG_AUX_BANK:    r_cfg_aux   <= i_cfg_wdata[0];
                REG_COLUMNS:     r_cfg_cols  <= i_cfg_wdata[7:0];
                REG_ROWS:        r_cfg_rows  <= i_cfg_wdata[7:0];
                REG_FILL_GLYPH:  r_cfg_glyph <= i_cfg_wdata[7:0];
                REG_FILL_ATTR:   r_cfg_attr  <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // Item register
    t_cmd_code   r_cmd;
    logic        r_arm;
    logic        r_act;
    logic        r_armed;
    logic        r_busy;
    logic [23:0] r_addr;
    logic [7:0]  r_wdata;
    logic [7:0]  r_code;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= t_cmd_code'(i_in_tuser);
            r_arm   <= i_in_tdata[0];
            r_act   <= i_in_tdata[1];
            r_armed <= i_in_tdata[2];
            r_busy  <= i_in_tdata[3];
            r_addr  <= i_in_tdata[27:4];
            r_wdata <= i_in_tdata[35:28];
            r_code  <= i_in_tdata[43:36];
        end
    end

    // Capture state latched at arm time
    logic        r_valid;
    logic        r_slot;
    logic [15:0] r_lat_base;
    logic        r_lat_aux;
    logic [16:0] r_bytes;
    logic [CNT_W-1:0] r_fill_cnt;

    logic [15:0] w_prod;
    assign w_prod = {8'd0, r_cfg_cols} * {8'd0, r_cfg_rows};

    logic [CNT_W-1:0] w_limit;
    logic             w_fill_clip;
    assign w_fill_clip = ({1'b0, r_bytes} > SLOT_LIMIT);
    assign w_limit     = w_fill_clip ? SLOT_LIMIT : {1'b0, r_bytes};

    // Bus write decode against the latched window
    logic [15:0]      w_addr_lo;
    logic [CNT_W-1:0] w_end;
    logic [15:0]      w_off;
    logic             w_hit;
    logic             w_in_slot;
    logic             w_store;

    assign w_addr_lo = r_addr[15:0];
    assign w_end     = {2'b00, r_lat_base} + {1'b0, r_bytes};
    assign w_off     = w_addr_lo - r_lat_base;
    assign w_hit     = r_valid && (r_addr[23:17] == 7'd0) && (r_addr[16] == r_lat_aux)
                       && (w_addr_lo >= r_lat_base) && ({2'b00, w_addr_lo} < w_end);
    assign w_in_slot = ({2'b00, w_off} < SLOT_LIMIT);
    assign w_store   = (r_cmd == CMD_WRITE) && w_hit && w_in_slot;

    logic w_next_valid;
    always_comb begin
        w_next_valid = r_valid;
        case (r_cmd)
            CMD_POLL: begin
                if (!r_armed && !r_busy) begin
                    w_next_valid = 1'b0;
                end
            end
            CMD_GAP:  w_next_valid = 1'b0;
            default:  w_next_valid = r_valid;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_slot     <= 1'b0;
            r_lat_base <= '0;
            r_lat_aux  <= 1'b0;
            r_bytes    <= '0;
            r_fill_cnt <= '0;
        end else begin
            if (i_cmd.arm_start) begin
                r_valid    <= 1'b0;
                r_slot     <= ~r_act;
                r_lat_base <= r_cfg_base;
                r_lat_aux  <= r_cfg_aux;
                r_bytes    <= {w_prod, 1'b0};
                r_fill_cnt <= '0;
            end else if (i_cmd.fill_step) begin
                r_fill_cnt <= r_fill_cnt + CNT_W'(1);
            end else if (i_cmd.ack_commit) begin
                r_valid <= 1'b1;
            end else if (i_cmd.commit) begin
                r_valid <= w_next_valid;
            end
        end
    end

    // Shadow store: slot s occupies [s*SLOT_BYTES, (s+1)*SLOT_BYTES)
    logic [7:0]    r_store [MEM_DEPTH];
    logic          w_mem_we;
    logic [AW-1:0] w_mem_idx;
    logic [7:0]    w_mem_data;
    logic [AW-1:0] w_slot_base;

    assign w_slot_base = r_slot ? SLOT_BASE : '0;

    always_comb begin
        if (i_cmd.fill_step) begin
            w_mem_we   = 1'b1;
            w_mem_idx  = w_slot_base + AW'(r_fill_cnt);
            w_mem_data = r_fill_cnt[0] ? r_cfg_attr : r_cfg_glyph;
        end else begin
            w_mem_we   = i_cmd.commit && w_store;
            w_mem_idx  = w_slot_base + AW'(w_off);
            w_mem_data = r_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_idx] <= w_mem_data;
        end
    end

    // Result register
    logic                r_out_valid;
    logic                r_out_ack;
    logic                r_out_aslot;
    logic                r_out_stale;
    logic                r_out_drained;
    logic                r_out_cvalid;
    logic                r_out_stored;
    logic [OFFSET_W-1:0] r_out_offset;
    logic                r_out_clipped;

    logic w_out_free;
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit || i_cmd.ack_commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ack_commit) begin
            r_out_ack     <= 1'b1;
            r_out_aslot   <= r_slot;
            r_out_stale   <= 1'b0;
            r_out_drained <= 1'b0;
            r_out_cvalid  <= 1'b1;
            r_out_stored  <= 1'b0;
            r_out_offset  <= '0;
            r_out_clipped <= w_fill_clip;
        end else if (i_cmd.commit) begin
            r_out_ack     <= 1'b0;
            r_out_aslot   <= 1'b0;
            r_out_stale   <= (r_cmd == CMD_GAP);
            r_out_drained <= (r_cmd == CMD_RECORD) && (r_code == RECORD_SHOW);
            r_out_cvalid  <= w_next_valid;
            r_out_stored  <= w_store;
            r_out_offset  <= w_store ? w_off[OFFSET_W-1:0] : '0;
            r_out_clipped <= (r_cmd == CMD_WRITE) && w_hit && !w_in_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_tdata = {4'b0000, r_out_clipped, r_out_offset, r_out_stored, r_out_cvalid,
                          r_out_drained, r_out_stale, r_out_aslot, r_out_ack};

    assign o_sts.is_arm    = (r_cmd == CMD_POLL) && r_arm;
    assign o_sts.fill_done = (r_fill_cnt >= w_limit);
    assign o_sts.out_free  = w_out_free;

    // Checks
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit || i_cmd.ack_commit) |-> w_out_free)
        else $error("result loaded over an untaken result");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> (r_fill_cnt < SLOT_LIMIT))
        else $error("fill ran past the slot");

    a_store_in_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && w_store) |-> (r_valid && ({2'b00, w_off} < SLOT_LIMIT)))
        else $error("bus write stored outside the capture slot");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_ack || r_out_stored)) |-> (r_out_cvalid && !r_out_stale))
        else $error("ack or store reported without a valid capture");

endmodule

// File: test/text_window_write_capture_tb.sv
// Self-checking testbench for text_window_write_capture: directed table, then random phases.
// Checks results against table rows or a capture predictor; depends on twwc_pkg and the RTL.

module text_window_write_capture_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twwc_pkg::*;

    localparam int SLOT_BYTES = DEF_SLOT_BYTES;
    localparam int LIMIT = 1_000_000;

    typedef struct packed {
        t_cmd_code   cmd;
        logic        arm;
        logic        act;
        logic        armed;
        logic        busy;
        logic [23:0] addr;
        logic [7:0]  data;
        logic [7:0]  code;
    } item_t;

    // Same bit order as m_axis_tdata[19:0]
    typedef struct packed {
        logic                clipped;
        logic [OFFSET_W-1:0] offset;
        logic                stored;
        logic                valid;
        logic                drained;
        logic                stale;
        logic                slot;
        logic                ack;
    } result_t;

    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t want;
    } row_t;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // arm_request, active_slot, armed_flag, busy_flag, write_address[23:0],
    // write_data[7:0], record_code[7:0], zero pad
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // command[1:0]
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // ack_arm, armed_slot, mark_stale, show_drained, capture_valid,
    // write_stored, store_offset[12:0], window_clipped, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    text_window_write_capture #(
        .SLOT_BYTES(SLOT_BYTES)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Register copies, window latched at arm, capture state
    logic [15:0] cfg_base = '0;
    logic        cfg_aux = 1'b0;
    logic [7:0]  cfg_cols = '0;
    logic [7:0]  cfg_rows = '0;
    logic [15:0] win_base = '0;
    logic        win_aux = 1'b0;
    logic [7:0]  win_cols = '0;
    logic [7:0]  win_rows = '0;
    logic        cap_valid = 1'b0;
    logic        cap_slot = 1'b0;

    result_t pending_results[$];
    row_t    dir_rows[$];
    bit      calm = 1'b0;
    int      arm_budget = 0;
    int      fails = 0;
    int      cycles = 0;
    int      items_sent = 0;
    int      n_results = 0;
    int      n_arms = 0;
    int      n_stores = 0;
    int      n_clipped = 0;
    int      n_stale = 0;
    int      n_drained = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic item_t mk_item(t_cmd_code cmd, logic arm, logic act, logic armed,
                                      logic busy, logic [23:0] addr, logic [7:0] data,
                                      logic [7:0] code);
        item_t it;
        it.cmd = cmd;
        it.arm = arm;
        it.act = act;
        it.armed = armed;
        it.busy = busy;
        it.addr = addr;
        it.data = data;
        it.code = code;
        return it;
    endfunction

    function automatic result_t res(logic ack, logic slot, logic stale, logic drained,
                                    logic valid, logic stored, logic [OFFSET_W-1:0] offset,
                                    logic clipped);
        result_t r;
        r.ack = ack;
        r.slot = slot;
        r.stale = stale;
        r.drained = drained;
        r.valid = valid;
        r.stored = stored;
        r.offset = offset;
        r.clipped = clipped;
        return r;
    endfunction

    // Advance the capture state by one transaction and return its result
    function automatic result_t capture_predict(item_t it);
        result_t r;
        int      span;
        int      off;
        r = '0;
        span = 2 * int'(win_cols) * int'(win_rows);
        case (it.cmd)
            CMD_POLL: begin
                if (it.arm) begin
                    win_base = cfg_base;
                    win_aux = cfg_aux;
                    win_cols = cfg_cols;
                    win_rows = cfg_rows;
                    span = 2 * int'(win_cols) * int'(win_rows);
                    cap_slot = ~it.act;
                    cap_valid = 1'b1;
                    r.ack = 1'b1;
                    r.slot = cap_slot;
                    r.clipped = span > SLOT_BYTES;
                end else if (!it.armed && !it.busy) begin
                    cap_valid = 1'b0;
                end
            end
            CMD_WRITE: begin
                if (cap_valid && it.addr[23:17] == 7'd0 && it.addr[16] == win_aux) begin
                    off = int'(it.addr[15:0]) - int'(win_base);
                    if (off >= 0 && off < span) begin
                        if (off < SLOT_BYTES) begin
                            r.stored = 1'b1;
                            r.offset = off[OFFSET_W-1:0];
                        end else begin
                            r.clipped = 1'b1;
                        end
                    end
                end
            end
            CMD_GAP: begin
                cap_valid = 1'b0;
                r.stale = 1'b1;
            end
            default: begin
                if (it.code == RECORD_SHOW) r.drained = 1'b1;
            end
        endcase
        r.valid = cap_valid;
        return r;
    endfunction

    // Mostly writes aimed at the latched window; arm again soon after the capture drops
    function automatic item_t rand_item(bit big);
        item_t       it;
        logic [31:0] rnd;
        logic [6:0]  hi;
        logic [15:0] a;
        int          pick;
        int          w;
        int          span;
        int          off;
        rnd = $urandom;
        it.cmd = CMD_WRITE;
        it.arm = 1'b0;
        it.act = rnd[0];
        it.armed = rnd[1];
        it.busy = rnd[2];
        it.data = rnd[15:8];
        it.code = rnd[23:16];
        rnd = $urandom;
        it.addr = rnd[23:0];
        pick = $urandom_range(0, 99);
        if (arm_budget > 0 && (pick < 3 || (!cap_valid && $urandom_range(0, 99) < 25))) begin
            it.cmd = CMD_POLL;
            it.arm = 1'b1;
            arm_budget--;
        end else if (pick < (big ? 4 : 8)) begin
            it.cmd = CMD_POLL;
        end else if (pick < (big ? 5 : 10)) begin
            it.cmd = CMD_GAP;
        end else if (pick < 14) begin
            it.cmd = CMD_RECORD;
            if (rnd[31]) it.code = RECORD_SHOW;
        end else begin
            span = 2 * int'(win_cols) * int'(win_rows);
            off = (span > 0) ? $urandom_range(0, span + 3) : $urandom_range(0, 7);
            a = win_base + off[15:0];
            hi = 7'($urandom_range(1, 127));
            w = $urandom_range(0, 99);
            if (w < 70) it.addr = {7'd0, win_aux, a};
            else if (w < 80) it.addr = {7'd0, ~win_aux, a};
            else if (w < 88) it.addr = {hi, win_aux, a};
        end
        return it;
    endfunction

    task automatic write_reg(t_reg_idx idx, logic [15:0] val);
        case (idx)
            REG_WINDOW_BASE: cfg_base = val;
            REG_AUX_BANK:    cfg_aux = val[0];
            REG_COLUMNS:     cfg_cols = val[7:0];
            REG_ROWS:        cfg_rows = val[7:0];
            default: ;
        endcase
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_window(logic [15:0] base, logic aux, logic [7:0] cols, logic [7:0] rows,
                              logic [7:0] glyph, logic [7:0] attr);
        write_reg(REG_WINDOW_BASE, base);
        write_reg(REG_AUX_BANK, {15'd0, aux});
        write_reg(REG_COLUMNS, {8'd0, cols});
        write_reg(REG_ROWS, {8'd0, rows});
        write_reg(REG_FILL_GLYPH, {8'd0, glyph});
        write_reg(REG_FILL_ATTR, {8'd0, attr});
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic send_item(item_t it, logic typed, result_t want);
        result_t pred;
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        pred = capture_predict(it);
        pending_results.push_back(typed ? want : pred);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, it.code, it.data, it.addr, it.busy, it.armed, it.act, it.arm};
        s_axis_tuser <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    // Hold off the sender until every result is in, then let the block settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [15:0] base, logic aux, logic [7:0] cols, logic [7:0] rows,
                             logic [7:0] glyph, logic [7:0] attr, int count, bit big,
                             int calm_items, int pause_at);
        set_window(base, aux, cols, rows, glyph, attr);
        arm_budget = big ? 6 : 1_000_000;
        send_item(mk_item(CMD_POLL, 1'b1, aux, 1'b0, 1'b0, '0, '0, '0), 1'b0, '0);
        for (int i = 0; i < count; i++) begin
            calm = i < calm_items;
            if (i == pause_at) wait_drained();
            send_item(rand_item(big), 1'b0, '0);
        end
        calm = 1'b0;
        wait_drained();
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("text_window_write_capture_tb: FAIL");
            $finish;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[19:0];
            n_results++;
            n_arms += got.ack;
            n_stores += got.stored;
            n_clipped += got.clipped;
            n_stale += got.stale;
            n_drained += got.drained;
            if (pending_results.size() == 0) begin
                $error("result 0x%06h with nothing expected", m_axis_tdata);
                fails++;
            end else begin
                want = pending_results.pop_front();
                check_field("ack_arm", want.ack, got.ack);
                check_field("armed_slot", want.slot, got.slot);
                check_field("mark_stale", want.stale, got.stale);
                check_field("show_drained", want.drained, got.drained);
                check_field("capture_valid", want.valid, got.valid);
                check_field("write_stored", want.stored, got.stored);
                check_field("store_offset", want.offset, got.offset);
                check_field("window_clipped", want.clipped, got.clipped);
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 21);
    end

    initial begin
        // Window 0x1000..0x100F in the main bank: 4 columns by 2 rows
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h001000, 8'h5A, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_POLL, 0, 0, 0, 0, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_RECORD, 0, 0, 0, 0, 24'h000000, 8'h00, RECORD_SHOW),
                             1'b1, res(0, 0, 0, 1, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_RECORD, 0, 0, 0, 0, 24'h000000, 8'h00, 8'hFF), 1'b1,
                             res(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_POLL, 1, 0, 0, 0, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(1, 1, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h001000, 8'hFF, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 1, 1, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h00100F, 8'h00, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 1, 1, 15, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h001010, 8'h11, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h000FFF, 8'h22, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h011000, 8'h33, 8'h00), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'hFE1000, 8'h44, 8'h00), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_WRITE, 1, 1, 1, 1, 24'h801005, 8'hA5, 8'hFF), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'hFFFFFF, 8'hFF, 8'h00), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_POLL, 0, 1, 1, 0, 24'h000000, 8'h00, 8'h00), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_POLL, 0, 0, 0, 1, 24'h000000, 8'h00, 8'h00), 1'b0,
                             '0});
        dir_rows.push_back('{mk_item(CMD_GAP, 0, 0, 0, 0, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(0, 0, 1, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h001000, 8'h77, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 0, 0, 0, 0)});
        // Arm wins over armed and busy
        dir_rows.push_back('{mk_item(CMD_POLL, 1, 1, 1, 1, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(1, 0, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_RECORD, 0, 0, 0, 0, 24'h000000, 8'h00, RECORD_SHOW),
                             1'b1, res(0, 0, 0, 1, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_POLL, 0, 0, 0, 0, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(0, 0, 0, 0, 0, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_POLL, 1, 0, 0, 0, 24'h000000, 8'h00, 8'h00), 1'b1,
                             res(1, 1, 0, 0, 1, 0, 0, 0)});
        dir_rows.push_back('{mk_item(CMD_WRITE, 0, 0, 0, 0, 24'h001007, 8'h00, 8'h00), 1'b0,
                             '0});

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_window(16'h1000, 1'b0, 8'd4, 8'd2, 8'h41, 8'h07);
        foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        // Window near the top of the address space, auxiliary bank
        run_phase(16'hFFF0, 1'b1, 8'd8, 8'd4, 8'hFF, 8'hFF, 250, 1'b0, 0, -1);
        // Empty window at the highest base
        run_phase(16'hFFFF, 1'b1, 8'd0, 8'd0, 8'h00, 8'h00, 150, 1'b0, 0, -1);
        // Window exactly one slot long
        run_phase(16'h0000, 1'b0, 8'd64, 8'd64, 8'h20, 8'h1F, 120, 1'b1, 0, -1);
        // Largest window: fill and most writes clipped
        run_phase(16'h0100, 1'b0, 8'd255, 8'd255, 8'hFF, 8'h00, 120, 1'b1, 0, -1);
        // Window somewhat over one slot
        run_phase(16'h4000, 1'b1, 8'd100, 8'd50, 8'h00, 8'hFF, 150, 1'b1, 0, -1);
        // Small window; no idling at the start, one full drain midway
        run_phase(16'h1234, 1'b1, 8'd20, 8'd10, 8'h2E, 8'h70, 700, 1'b0, 200, 350);

        $display("sent %0d transactions, checked %0d results in %0d cycles",
                 items_sent, n_results, cycles);
        $display("arms %0d, stores %0d, clipped %0d, stale %0d, show drained %0d",
                 n_arms, n_stores, n_clipped, n_stale, n_drained);
        if (fails == 0) begin
            $display("text_window_write_capture_tb: PASS");
        end else begin
            $display("text_window_write_capture_tb: FAIL");
        end
        $finish;
    end

endmodule
